// File: sv/iptc_dataset_stream_parser_core_assert.svh
// ---------------------------------------------------------------------------
// IPTC dataset stream parser assertion macros
// Clocked property checks with a synchronous reset guard.
// ---------------------------------------------------------------------------
`ifndef IPTC_DATASET_STREAM_PARSER_CORE_ASSERT_SVH
`define IPTC_DATASET_STREAM_PARSER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold on every edge outside reset
`define IDSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset
`define IDSP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IDSP_ASSERT(lbl, clk, rst, prop, msg)
`define IDSP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: sv/idsp_pkg.sv
// ---------------------------------------------------------------------------
// IPTC dataset stream parser package
// Shared codes, limits, and item/result types.
// ---------------------------------------------------------------------------
`default_nettype none

package idsp_pkg;

  // Default width of the dataset counter
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // IIM framing constants
  localparam logic [7:0] IIM_MARKER        = 8'h1C;
  localparam int         MIN_DATASET_BYTES = 5;
  localparam int         MAX_EXT_LEN_BYTES = 4;

  // Register reset values
  localparam logic [31:0] MAX_DATASET_COUNT_RST = 32'd200000;
  localparam logic [31:0] MAX_VALUE_LENGTH_RST  = 32'd8388608;
  localparam logic [31:0] MAX_TOTAL_LENGTH_RST  = 32'd67108864;

  // Result queue depth (power of two, at least two)
  localparam int RES_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_END    = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNSUPPORTED = 2'd1,
    STATUS_MALFORMED   = 2'd2,
    STATUS_LIMIT       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_DATASET_COUNT = 2'd0,
    REG_MAX_VALUE_LENGTH  = 2'd1,
    REG_MAX_TOTAL_LENGTH  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [31:0] max_dataset_count;
    logic [31:0] max_value_length;
    logic [31:0] max_total_length;
  } cfg_regs_t;

  typedef struct packed {
    logic [31:0] buffer_size;
    logic        last_byte;
    logic        first_byte;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic         last_result;
    logic [31:0]  datasets_decoded;
    status_t      final_status;
    logic         value_end;
    logic [7:0]   value_byte;
    logic [31:0]  dataset_order;
    logic [31:0]  value_length;
    logic [7:0]   dataset_number;
    logic [7:0]   record_number;
    result_kind_t result_kind;
  } result_t;

endpackage

`default_nettype wire

// File: sv/iptc_dataset_stream_parser_core.sv
// ---------------------------------------------------------------------------
// IPTC dataset stream parser core
// Parses an IPTC IIM buffer one byte per request into dataset headers,
// value bytes, and an end status.
// ---------------------------------------------------------------------------
//  channel | signals                                    | payload
//  s_*     | s_tvalid s_tready s_tdata s_tlast s_tuser  | buffer byte, size, first/last
//  m_*     | m_tvalid m_tready m_tdata m_tlast m_tuser  | header, value byte, end status
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data     | limit register writes
//
//  One byte is accepted per cycle while the result queue has room; results
//  pass through the input register, then the result queue. A byte gives
//  zero to two results; only a last byte that also yields a header or a
//  value byte gives two. The input side stalls when the four-entry result
//  queue lacks room for two results. Synchronous reset clears parse state
//  and loads the limit registers with their defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module iptc_dataset_stream_parser_core #(
  parameter int COUNT_WIDTH = idsp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,   // data_byte[7:0], buffer_size[39:8]
  input  wire logic         s_tlast,
  input  wire logic         s_tuser,   // first_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // record_number[7:0], dataset_number[15:8], value_length[47:16],
  // dataset_order[79:48], value_byte[87:80], value_end[88],
  // final_status[90:89], datasets_decoded[122:91], zero[127:123]
  output logic [127:0]      m_tdata,
  output logic              m_tlast,
  output logic [1:0]        m_tuser,   // result_kind[1:0]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  idsp_pkg::cfg_regs_t cfg;
  idsp_pkg::in_item_t  in_item;
  logic                in_valid;
  logic                step;
  logic                room_for_two;
  idsp_pkg::result_t   res0;
  idsp_pkg::result_t   res1;
  logic [1:0]          res_count;
  idsp_pkg::result_t   out_res;

  assign cfg_ready = 1'b1;

  // Write limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_dataset_count <= idsp_pkg::MAX_DATASET_COUNT_RST;
      cfg.max_value_length  <= idsp_pkg::MAX_VALUE_LENGTH_RST;
      cfg.max_total_length  <= idsp_pkg::MAX_TOTAL_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (idsp_pkg::reg_index_t'(cfg_index))
        idsp_pkg::REG_MAX_DATASET_COUNT: cfg.max_dataset_count <= cfg_data;
        idsp_pkg::REG_MAX_VALUE_LENGTH:  cfg.max_value_length  <= cfg_data;
        idsp_pkg::REG_MAX_TOTAL_LENGTH:  cfg.max_total_length  <= cfg_data;
        default: cfg.max_dataset_count <= cfg.max_dataset_count;
      endcase
    end
  end

  // Input register: drain into the parser when the queue has room
  assign step     = in_valid && room_for_two;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte   <= s_tdata[7:0];
      in_item.buffer_size <= s_tdata[39:8];
      in_item.first_byte  <= s_tuser;
      in_item.last_byte   <= s_tlast;
    end
  end

  idsp_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .cfg       (cfg),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  idsp_result_fifo u_result_fifo (
    .clk          (clk),
    .rst          (rst),
    .wr_count     (res_count),
    .wr_data0     (res0),
    .wr_data1     (res1),
    .room_for_two (room_for_two),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (out_res)
  );

  // Pack the result request
  assign m_tdata = {5'd0, out_res.datasets_decoded, out_res.final_status,
                    out_res.value_end, out_res.value_byte, out_res.dataset_order,
                    out_res.value_length, out_res.dataset_number,
                    out_res.record_number};
  assign m_tlast = out_res.last_result;
  assign m_tuser = out_res.result_kind;

endmodule

`default_nettype wire

// File: sv/idsp_parser.sv
// ---------------------------------------------------------------------------
// IPTC dataset parser step
// Holds the parse state and turns one byte into up to two results.
// ---------------------------------------------------------------------------
`default_nettype none

module idsp_parser #(
  parameter int COUNT_WIDTH = idsp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire idsp_pkg::in_item_t  item,
  input  wire idsp_pkg::cfg_regs_t cfg,
  output idsp_pkg::result_t        res0,
  output idsp_pkg::result_t        res1,
  output logic [1:0]               res_count
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  typedef enum logic [2:0] {
    PH_MARKER, PH_RECORD, PH_DATASET, PH_LENHI,
    PH_LENLO, PH_EXT, PH_VALUE, PH_SWALLOW
  } phase_t;

  // Parse state
  phase_t                   phase;
  logic [31:0]              pos;
  logic [31:0]              size;
  logic [7:0]               rec;
  logic [7:0]               dset;
  logic [31:0]              lacc;
  logic [2:0]               ebl;
  logic [31:0]              vbl;
  logic [COUNT_WIDTH-1:0]   cnt;
  logic [32:0]              sum;
  idsp_pkg::status_t        status;
  logic [31:0]              order;

  // State as seen after a restart on the first byte
  phase_t                   e_phase;
  logic [31:0]              e_pos;
  logic [31:0]              e_size;
  logic [7:0]               e_rec;
  logic [7:0]               e_dset;
  logic [31:0]              e_lacc;
  logic [2:0]               e_ebl;
  logic [31:0]              e_vbl;
  logic [COUNT_WIDTH-1:0]   e_cnt;
  logic [32:0]              e_sum;
  idsp_pkg::status_t        e_status;
  logic [31:0]              e_order;

  phase_t                   phase_next;
  logic [31:0]              pos_next;
  logic [7:0]               rec_next;
  logic [7:0]               dset_next;
  logic [31:0]              lacc_next;
  logic [2:0]               ebl_next;
  logic [31:0]              vbl_next;
  logic [COUNT_WIDTH-1:0]   cnt_next;
  logic [32:0]              sum_next;
  idsp_pkg::status_t        status_next;
  logic [31:0]              order_next;

  // Intermediate values
  logic [7:0]               b;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         mdc_ext;
  logic [15:0]              len16;
  logic [14:0]              ext_cnt;
  logic [31:0]              ext_len;
  logic [2:0]               ebl_dec;
  logic                     fin_req;
  logic [31:0]              fin_len;
  logic [32:0]              off;
  logic [32:0]              sum_add;
  logic                     pemit;
  logic                     eemit;
  idsp_pkg::result_t        pres;
  idsp_pkg::result_t        eres;

  assign b = item.data_byte;

  // Restart on the first byte of a buffer
  always_comb begin
    e_phase  = phase;
    e_pos    = pos;
    e_size   = size;
    e_rec    = rec;
    e_dset   = dset;
    e_lacc   = lacc;
    e_ebl    = ebl;
    e_vbl    = vbl;
    e_cnt    = cnt;
    e_sum    = sum;
    e_status = status;
    e_order  = order;
    if (item.first_byte) begin
      e_pos    = '0;
      e_size   = item.buffer_size;
      e_rec    = '0;
      e_dset   = '0;
      e_lacc   = '0;
      e_ebl    = '0;
      e_vbl    = '0;
      e_cnt    = '0;
      e_sum    = '0;
      e_status = idsp_pkg::STATUS_OK;
      e_order  = '0;
      e_phase  = PH_MARKER;
      if (item.buffer_size == '0 || b != idsp_pkg::IIM_MARKER) begin
        e_status = idsp_pkg::STATUS_UNSUPPORTED;
        e_phase  = PH_SWALLOW;
      end else if (cfg.max_total_length != '0 &&
                   item.buffer_size > cfg.max_total_length) begin
        e_status = idsp_pkg::STATUS_LIMIT;
        e_phase  = PH_SWALLOW;
      end
    end
  end

  // Parse one byte, then check the finished length, then close the buffer
  always_comb begin
    phase_next  = e_phase;
    rec_next    = e_rec;
    dset_next   = e_dset;
    lacc_next   = e_lacc;
    ebl_next    = e_ebl;
    vbl_next    = e_vbl;
    cnt_next    = e_cnt;
    sum_next    = e_sum;
    status_next = e_status;
    order_next  = e_order;
    pos_next    = (e_pos != '1) ? e_pos + 32'd1 : e_pos;

    cnt_ext = CMP_W'(e_cnt);
    mdc_ext = CMP_W'(cfg.max_dataset_count);
    len16   = {e_lacc[7:0], b};
    ext_cnt = len16[14:0];
    ext_len = {e_lacc[23:0], b};
    ebl_dec = e_ebl - 3'd1;
    fin_req = 1'b0;
    fin_len = '0;
    off     = {1'b0, e_pos} + 33'd1;
    pemit   = 1'b0;
    pres    = '0;
    eemit   = 1'b0;
    eres    = '0;

    if (e_pos < e_size) begin
      unique case (e_phase)
        PH_MARKER: begin
          if (cnt_ext >= mdc_ext) begin
            status_next = idsp_pkg::STATUS_LIMIT;
            phase_next  = PH_SWALLOW;
          end else if ((e_size - e_pos) < 32'(idsp_pkg::MIN_DATASET_BYTES)) begin
            status_next = idsp_pkg::STATUS_MALFORMED;
            phase_next  = PH_SWALLOW;
          end else if (b != idsp_pkg::IIM_MARKER) begin
            status_next = idsp_pkg::STATUS_MALFORMED;
            phase_next  = PH_SWALLOW;
          end else begin
            phase_next = PH_RECORD;
          end
        end
        PH_RECORD: begin
          rec_next   = b;
          phase_next = PH_DATASET;
        end
        PH_DATASET: begin
          dset_next  = b;
          phase_next = PH_LENHI;
        end
        PH_LENHI: begin
          lacc_next  = {24'd0, b};
          phase_next = PH_LENLO;
        end
        PH_LENLO: begin
          if (!len16[15]) begin
            fin_req = 1'b1;
            fin_len = {16'd0, len16};
          end else if (ext_cnt == '0 ||
                       ext_cnt > 15'(idsp_pkg::MAX_EXT_LEN_BYTES)) begin
            status_next = idsp_pkg::STATUS_MALFORMED;
            phase_next  = PH_SWALLOW;
          end else if (({2'b0, e_pos} + 34'd1 + {19'd0, ext_cnt}) > {2'b0, e_size}) begin
            status_next = idsp_pkg::STATUS_MALFORMED;
            phase_next  = PH_SWALLOW;
          end else begin
            lacc_next  = '0;
            ebl_next   = ext_cnt[2:0];
            phase_next = PH_EXT;
          end
        end
        PH_EXT: begin
          lacc_next = ext_len;
          ebl_next  = ebl_dec;
          if (ebl_dec == '0) begin
            fin_req = 1'b1;
            fin_len = ext_len;
          end
        end
        PH_VALUE: begin
          pemit              = 1'b1;
          pres.result_kind   = idsp_pkg::KIND_VALUE;
          pres.record_number = e_rec;
          pres.dataset_number = e_dset;
          pres.dataset_order = e_order;
          pres.value_byte    = b;
          pres.value_end     = (e_vbl == 32'd1);
          vbl_next           = e_vbl - 32'd1;
          if (e_vbl == 32'd1) begin
            phase_next = PH_MARKER;
          end
        end
        PH_SWALLOW: begin
          phase_next = e_phase;
        end
      endcase
    end

    // Check a completed length and emit the header
    sum_add = e_sum + {1'b0, fin_len};
    if (fin_req) begin
      if (fin_len > cfg.max_value_length) begin
        status_next = idsp_pkg::STATUS_LIMIT;
        phase_next  = PH_SWALLOW;
      end else if (off > {1'b0, e_size} || {1'b0, fin_len} > ({1'b0, e_size} - off)) begin
        status_next = idsp_pkg::STATUS_MALFORMED;
        phase_next  = PH_SWALLOW;
      end else begin
        sum_next = sum_add;
        if (cfg.max_total_length != '0 && sum_add > {1'b0, cfg.max_total_length}) begin
          status_next = idsp_pkg::STATUS_LIMIT;
          phase_next  = PH_SWALLOW;
        end else begin
          order_next = cnt_ext[31:0];
          if (e_cnt != '1) begin
            cnt_next = e_cnt + COUNT_WIDTH'(1);
          end
          pemit               = 1'b1;
          pres.result_kind    = idsp_pkg::KIND_HEADER;
          pres.record_number  = e_rec;
          pres.dataset_number = e_dset;
          pres.value_length   = fin_len;
          pres.dataset_order  = cnt_ext[31:0];
          vbl_next            = fin_len;
          phase_next          = (fin_len != '0) ? PH_VALUE : PH_MARKER;
        end
      end
    end

    // Close the buffer on its last byte
    if (item.last_byte) begin
      if (status_next == idsp_pkg::STATUS_OK && off < {1'b0, e_size}) begin
        status_next = idsp_pkg::STATUS_MALFORMED;
      end
      eemit                 = 1'b1;
      eres.result_kind      = idsp_pkg::KIND_END;
      eres.final_status     = status_next;
      eres.datasets_decoded = 32'(cnt_next);
      eres.last_result      = 1'b1;
      phase_next            = PH_SWALLOW;
    end
    pres.last_result = !eemit;
  end

  // Order results: parse result first, end result after it
  always_comb begin
    res0      = pemit ? pres : eres;
    res1      = eres;
    res_count = {1'b0, pemit} + {1'b0, eemit};
    if (!step) begin
      res_count = 2'd0;
    end
  end

  // Hold parse state, advance on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_MARKER;
      pos    <= '0;
      size   <= '0;
      rec    <= '0;
      dset   <= '0;
      lacc   <= '0;
      ebl    <= '0;
      vbl    <= '0;
      cnt    <= '0;
      sum    <= '0;
      status <= idsp_pkg::STATUS_OK;
      order  <= '0;
    end else if (step) begin
      phase  <= phase_next;
      pos    <= pos_next;
      size   <= e_size;
      rec    <= rec_next;
      dset   <= dset_next;
      lacc   <= lacc_next;
      ebl    <= ebl_next;
      vbl    <= vbl_next;
      cnt    <= cnt_next;
      sum    <= sum_next;
      status <= status_next;
      order  <= order_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/idsp_result_fifo.sv
// ---------------------------------------------------------------------------
// IPTC parser result queue
// Small queue taking up to two results per cycle and giving one when the reader is ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "iptc_dataset_stream_parser_core_assert.svh"

module idsp_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        wr_count,
  input  wire idsp_pkg::result_t wr_data0,
  input  wire idsp_pkg::result_t wr_data1,
  output logic                   room_for_two,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output idsp_pkg::result_t      out_data
);

  localparam int DEPTH = idsp_pkg::RES_FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  idsp_pkg::result_t mem [DEPTH];
  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic [CW-1:0]     count;
  logic              pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != '0);
  assign out_data     = mem[rp];
  assign room_for_two = (CW'(DEPTH) - count) >= CW'(2);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(wr_count);
      rp    <= rp + PW'(pop);
      count <= count + CW'(wr_count) - CW'(pop);
    end
  end

  // Store results; the second one lands in the next slot (wraps)
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wp] <= wr_data0;
    end
    if (wr_count == 2'd2) begin
      mem[wp + PW'(1)] <= wr_data1;
    end
  end

  `IDSP_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "result queue over depth")
  `IDSP_ASSERT_NEVER(a_no_overflow, clk, rst, (CW'(DEPTH) - count) < CW'(wr_count), "result queue overflow")
  `IDSP_ASSERT(a_count_track, clk, rst, 1'b1 |=> (count == $past(count) + CW'($past(wr_count)) - CW'($past(pop))), "result queue count mismatch")

endmodule

`default_nettype wire
